### rtl/pll_fm_demodulator_core_assert.svh
// Assertion macros for the checker file.
`ifndef PLL_FM_DEMODULATOR_CORE_ASSERT_SVH
`define PLL_FM_DEMODULATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PFM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/pfm_pkg.sv
package pfm_pkg;

   localparam int CordicSteps = 24;
   localparam int Prescale    = 14;
   localparam int StepBits    = $clog2(CordicSteps);

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_PROP_GAIN  = 3'd0,
      REG_INTEG_GAIN = 3'd1,
      REG_FREQ_MIN   = 3'd2,
      REG_FREQ_MAX   = 3'd3,
      REG_DC_KEEP    = 3'd4,
      REG_DC_TAKE    = 3'd5,
      REG_OUT_GAIN   = 3'd6
   } reg_index_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROT,
      OP_ERR,
      OP_MUL,
      OP_ADD,
      OP_CLAMP,
      OP_FILT,
      OP_DC1,
      OP_DC2,
      OP_DCSUM,
      OP_DIFF,
      OP_GAIN,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic rot_last;
   } status_type;

   // Arctangent of 2^-k in 2^32 units per turn
   function automatic logic [31:0] atan_lookup(input logic [StepBits-1:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

### rtl/pfm_ctrl.sv
module pfm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pfm_pkg::status_type status,
   output pfm_pkg::cmd_type   cmd
);
   import pfm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROT, ST_ERR, ST_MUL, ST_ADD, ST_CLAMP, ST_FILT,
      ST_DC1, ST_DC2, ST_DCSUM, ST_DIFF, ST_GAIN, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode state into datapath command and next state
   always_comb begin
      cmd.op       = OP_NONE;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cmd.op = OP_ROT;
            if (status.rot_last) state_in = ST_ERR;
         end
         ST_ERR:   begin cmd.op = OP_ERR;   state_in = ST_MUL;   end
         ST_MUL:   begin cmd.op = OP_MUL;   state_in = ST_ADD;   end
         ST_ADD:   begin cmd.op = OP_ADD;   state_in = ST_CLAMP; end
         ST_CLAMP: begin cmd.op = OP_CLAMP; state_in = ST_FILT;  end
         ST_FILT:  begin cmd.op = OP_FILT;  state_in = ST_DC1;   end
         ST_DC1:   begin cmd.op = OP_DC1;   state_in = ST_DC2;   end
         ST_DC2:   begin cmd.op = OP_DC2;   state_in = ST_DCSUM; end
         ST_DCSUM: begin cmd.op = OP_DCSUM; state_in = ST_DIFF;  end
         ST_DIFF:  begin cmd.op = OP_DIFF;  state_in = ST_GAIN;  end
         ST_GAIN:  begin cmd.op = OP_GAIN;  state_in = ST_DONE;  end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/pfm_datapath.sv
module pfm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pfm_pkg::cmd_type    cmd,
   output pfm_pkg::status_type status,
   input  logic signed [15:0]  req_i_sample,
   input  logic signed [15:0]  req_q_sample,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic signed [15:0]  rsp_audio_out
);
   import pfm_pkg::*;

   // configuration registers
   logic [16:0]        prop_gain_ff, integ_gain_ff;
   logic signed [31:0] freq_min_ff, freq_max_ff;
   logic [23:0]        dc_keep_ff, dc_take_ff, out_gain_ff;

   // loop state
   logic [31:0]        nco_ff;
   logic signed [31:0] integ_ff, filt_ff, dc_ff;

   // working registers
   logic signed [33:0] x_ff, y_ff;
   logic [31:0]        z_ff;
   logic [StepBits-1:0] k_ff;
   logic               zero_ff;
   logic signed [15:0] err_ff;
   logic signed [33:0] pi_ff, pp_ff;
   logic signed [34:0] t_ff;
   logic signed [56:0] m1_ff, m2_ff;
   logic signed [32:0] diff_ff;
   logic signed [57:0] a_ff;
   logic signed [15:0] audio_ff;

   // combinational helpers
   logic signed [33:0] xi, yq, xs, ys;
   logic [31:0]        dphase;
   logic [31:0]        dround;
   logic signed [34:0] tc, fsum, lo35, hi35;
   logic signed [57:0] dsum;
   logic signed [33:0] dshift;
   logic signed [25:0] ashift;

   assign status.rot_last = (k_ff == StepBits'(CordicSteps - 1));
   assign rsp_audio_out   = audio_ff;

   assign xi     = {{(34-16-Prescale){req_i_sample[15]}}, req_i_sample, {Prescale{1'b0}}};
   assign yq     = {{(34-16-Prescale){req_q_sample[15]}}, req_q_sample, {Prescale{1'b0}}};
   assign xs     = x_ff >>> k_ff;
   assign ys     = y_ff >>> k_ff;
   assign dphase = z_ff - nco_ff;
   assign dround = dphase + 32'h0000_8000;
   assign lo35   = 35'(freq_min_ff);
   assign hi35   = 35'(freq_max_ff);
   assign fsum   = 35'(pp_ff) + 35'(integ_ff);
   assign dsum   = 58'(m1_ff) + 58'(m2_ff) + 58'sd8388608;
   assign dshift = dsum[57:24];
   assign ashift = a_ff[57:32];

   // clamp low first, then high
   always_comb begin
      tc = (t_ff < lo35) ? lo35 : t_ff;
      if (tc > hi35) tc = hi35;
   end

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= 17'd37054;
         integ_gain_ff <= 17'd7615;
         freq_min_ff   <= -32'sd357913941;
         freq_max_ff   <= 32'sd357913941;
         dc_keep_ff    <= 24'd16759750;
         dc_take_ff    <= 24'd17466;
         out_gain_ff   <= 24'd629146;
      end else if (csr_write) begin
         case (csr_index)
            REG_PROP_GAIN:  prop_gain_ff  <= csr_data[16:0];
            REG_INTEG_GAIN: integ_gain_ff <= csr_data[16:0];
            REG_FREQ_MIN:   freq_min_ff   <= csr_data;
            REG_FREQ_MAX:   freq_max_ff   <= csr_data;
            REG_DC_KEEP:    dc_keep_ff    <= csr_data[23:0];
            REG_DC_TAKE:    dc_take_ff    <= csr_data[23:0];
            REG_OUT_GAIN:   out_gain_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // advance loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         nco_ff   <= '0;
         integ_ff <= '0;
         filt_ff  <= '0;
         dc_ff    <= '0;
      end else begin
         case (cmd.op)
            OP_CLAMP: integ_ff <= tc[31:0];
            OP_FILT: begin
               nco_ff <= nco_ff + filt_ff;
               if (fsum > 35'sd2147483647)       filt_ff <= 32'sh7FFF_FFFF;
               else if (fsum < -35'sd2147483648) filt_ff <= 32'sh8000_0000;
               else                              filt_ff <= fsum[31:0];
            end
            OP_DCSUM: begin
               if (dshift > 34'sd2147483647)       dc_ff <= 32'sh7FFF_FFFF;
               else if (dshift < -34'sd2147483648) dc_ff <= 32'sh8000_0000;
               else                                dc_ff <= dshift[31:0];
            end
            default: ;
         endcase
      end
   end

   // run the working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            zero_ff <= (req_i_sample == 16'sd0) && (req_q_sample == 16'sd0);
            k_ff    <= '0;
            if (xi < 0) begin
               x_ff <= -xi;
               y_ff <= -yq;
               z_ff <= 32'h8000_0000;
            end else begin
               x_ff <= xi;
               y_ff <= yq;
               z_ff <= 32'h0;
            end
         end
         OP_ROT: begin
            k_ff <= k_ff + 1'b1;
            if (y_ff > 0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_lookup(k_ff);
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_lookup(k_ff);
            end
         end
         OP_ERR:  err_ff <= zero_ff ? 16'sd0 : $signed(dround[31:16]);
         OP_MUL: begin
            pi_ff <= err_ff * $signed({1'b0, integ_gain_ff});
            pp_ff <= err_ff * $signed({1'b0, prop_gain_ff});
         end
         OP_ADD:  t_ff  <= 35'(integ_ff) + 35'(pi_ff);
         OP_DC1:  m1_ff <= $signed({1'b0, dc_keep_ff}) * dc_ff;
         OP_DC2:  m2_ff <= $signed({1'b0, dc_take_ff}) * filt_ff;
         OP_DIFF: diff_ff <= 33'(filt_ff) - 33'(dc_ff);
         OP_GAIN: a_ff  <= 58'(diff_ff * $signed({1'b0, out_gain_ff}));
         OP_OUT: begin
            if (ashift > 26'sd32767)       audio_ff <= 16'sh7FFF;
            else if (ashift < -26'sd32768) audio_ff <= 16'sh8000;
            else                           audio_ff <= ashift[15:0];
         end
         default: ;
      endcase
   end

endmodule

### rtl/pll_fm_demodulator_core.sv
// PLL FM demodulator: one complex baseband request (I, Q) in, one 16-bit
// audio sample out. Each request runs one load step, 24 steps of the shared
// CORDIC vectoring step (one arctangent step per cycle), then eleven steps
// of loop filter, DC tracker and gain arithmetic, one multiply or wide add
// per cycle; the last step waits while the output register holds a stalled
// result. A new request is taken as soon as the previous one has been moved
// into the output register, even while that result still waits. Loop gains,
// integrator clamps, DC coefficients and audio gain are written through the
// csr port (always ready); the user must write them only while no request is
// in flight, which the block does not enforce. Loop state resets to zero.
module pll_fm_demodulator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_i_sample,
   input  logic signed [15:0] req_q_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_audio_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import pfm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_i_sample  (req_i_sample),
      .req_q_sample  (req_q_sample),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_audio_out (rsp_audio_out)
   );

endmodule

### rtl/pfm_checker.sv
`include "pll_fm_demodulator_core_assert.svh"

module pfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_audio_out,
   input logic        csr_ready
);

   // a stalled result stays
   `PFM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   // a stalled result keeps its payload
   `PFM_ASSERT_NEXT(a_rsp_data_hold, rsp_valid && rsp_stall, $stable(rsp_audio_out))
   // busy after taking a request
   `PFM_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   // a fresh request cannot produce a result at once
   `PFM_ASSERT_NEXT(a_no_instant_rsp, req_valid && !req_stall && !rsp_valid, !rsp_valid)
   // config port never blocks
   `PFM_ASSERT_NOW(a_csr_ready, 1'b1, csr_ready)

endmodule

bind pll_fm_demodulator_core pfm_checker u_pfm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_audio_out (rsp_audio_out),
   .csr_ready     (csr_ready)
);
